// ===== rtl/chm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Operation codes, controller states and the fixed field widths.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int KEY_W       = 64;
	localparam int VAL_W       = 32;
	localparam int OP_W        = 2;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 40;

	// Key magnitude bits retired per cycle by the bucket reduction.
	localparam int DIG_W     = 4;
	localparam int DIV_STEPS = KEY_W / DIG_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [VAL_W-1:0] ABSENT_VALUE = '1;

	typedef enum logic [OP_W-1:0] {
		OP_FIND   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_GET    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIV,
		ST_BKT,
		ST_HREAD,
		ST_HWAIT,
		ST_WALK,
		ST_ENT,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/chm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chm_ram: generic simple dual-port RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module chm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/chained_hash_map_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_map_core: key/value map with separate chaining
// Each operation runs through the bucket reduction, the head read and the
// chain walk, which visits one entry at a time until the key is found or the
// chain ends, then the update and the result. A clear answers after its sweep.
// One operation is taken at a time; the bucket reduction takes 4 bits/cycle
// and the walk reads the entry memory for each entry that it visits.
// After reset, and after every clear operation, the bucket head memory is
// swept to zero while no input transaction is taken.
// ----------------------------------------------------------------------------
module chained_hash_map_core #(
	parameter int BUCKET_COUNT = 1021,
	parameter int ENTRY_COUNT  = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// op[1:0], key[65:2], write_value[97:66], zero fill above.
	input  wire logic [chm_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// value[31:0], found[32], status[33], zero fill above.
	output logic      [chm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	import chm_pkg::*;

	// Bucket index width, link width (0 means end of chain) and slot width.
	localparam int BIW = $clog2(BUCKET_COUNT);
	localparam int LW  = $clog2(ENTRY_COUNT + 1);
	localparam int EIW = $clog2(ENTRY_COUNT);
	localparam int EW  = KEY_W + VAL_W + LW;

	localparam logic [BIW:0]   BC      = (BIW+1)'(BUCKET_COUNT);
	localparam logic [BIW-1:0] BC_LAST = BIW'(BUCKET_COUNT - 1);
	localparam logic [LW-1:0]  EC      = LW'(ENTRY_COUNT);

	state_t state_q, state_d;

	// Operation being worked on.
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  wv_q;
	logic              neg_q;

	// Bucket reduction: the magnitude shifts out from the top, DIG_W bits a cycle.
	logic [KEY_W-1:0]     mag_q;
	logic [BIW-1:0]       rem_q, rem_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [BIW-1:0]       bkt_q;

	// Chain walk.
	logic [LW-1:0]   head_q;
	logic [LW-1:0]   cur_q;
	logic [LW-1:0]   used_q;
	logic [EIW-1:0]  slot_q;
	logic [LW-1:0]   ent_next_q;
	logic [BIW-1:0]  clr_idx_q;
	// Set by the first input transaction; the sweep after reset answers nothing.
	logic            op_seen_q;

	// Result waiting for the output register.
	logic [VAL_W-1:0] res_value_q;
	logic             res_found_q;
	logic             res_status_q;

	// Output register.
	logic             m_valid_q;
	logic [VAL_W-1:0] m_value_q;
	logic             m_found_q;
	logic             m_status_q;

	// Memory ports.
	logic            head_we;
	logic [BIW-1:0]  head_waddr;
	logic [LW-1:0]   head_wdata, head_rdata;
	logic            ent_we;
	logic [EIW-1:0]  ent_waddr;
	logic [EW-1:0]   ent_wdata, ent_rdata;
	logic [EIW-1:0]  ent_raddr;

	logic s_acc;
	logic out_free;
	logic link_live;
	logic key_hit;
	logic pool_full;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign link_live = (cur_q != '0) && (cur_q <= used_q);
	assign key_hit   = (ent_rdata[EW-1 -: KEY_W] == key_q);
	assign pool_full = (used_q >= EC);
	assign ent_raddr = EIW'(cur_q - LW'(1));

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_status_q, m_found_q, m_value_q};

	// The bucket memory holds chain heads, the entry memory holds
	// {key, value, next link} for each pool slot.
	chm_ram #(.W(LW), .D(BUCKET_COUNT)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bkt_q),
		.rdata (head_rdata)
	);

	chm_ram #(.W(EW), .D(ENTRY_COUNT)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Restoring reduction of DIG_W key bits against the bucket count.
	always_comb begin
		logic [BIW:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIG_W; i++) begin
			r = {r[BIW-1:0], mag_q[KEY_W-1-i]};
			if (r >= BC) begin
				r = r - BC;
			end
		end
		rem_d = r[BIW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory write strobes.
	always_comb begin
		state_d    = state_q;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = '0;
		ent_we     = 1'b0;
		ent_waddr  = slot_q;
		ent_wdata  = {key_q, wv_q, ent_next_q};
		case (state_q)
			ST_CLR: begin
				head_we    = 1'b1;
				head_waddr = clr_idx_q;
				if (clr_idx_q == BC_LAST) begin
					// Only a clear operation has a result to hand out.
					state_d = op_seen_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_acc) begin
					state_d = (op_t'(s_tdata[1:0]) == OP_CLEAR) ? ST_CLR : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_BKT;
				end
			end
			ST_BKT:   state_d = ST_HREAD;
			ST_HREAD: state_d = ST_HWAIT;
			ST_HWAIT: state_d = ST_WALK;
			ST_WALK: begin
				state_d = link_live ? ST_ENT : ST_UPD;
			end
			ST_ENT: begin
				state_d = key_hit ? ST_UPD : ST_WALK;
			end
			ST_UPD: begin
				if (res_found_q) begin
					ent_we = (op_q == OP_WRITE);
				end else if (op_q != OP_FIND && !pool_full) begin
					// New key goes to the head of its chain in the next free slot.
					ent_we     = 1'b1;
					ent_waddr  = used_q[EIW-1:0];
					ent_wdata  = {key_q, (op_q == OP_WRITE) ? wv_q : ABSENT_VALUE, head_q};
					head_we    = 1'b1;
					head_wdata = used_q + LW'(1);
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			clr_idx_q <= '0;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
			op_seen_q <= 1'b0;
		end else begin
			if (s_acc) begin
				op_seen_q <= 1'b1;
			end
			if (state_q == ST_CLR) begin
				used_q    <= '0;
				clr_idx_q <= (clr_idx_q == BC_LAST) ? '0 : clr_idx_q + BIW'(1);
			end
			if (state_q == ST_UPD && !res_found_q && op_q != OP_FIND && !pool_full) begin
				used_q <= used_q + LW'(1);
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end else begin
				div_cnt_q <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					op_q         <= op_t'(s_tdata[1:0]);
					key_q        <= s_tdata[65:2];
					wv_q         <= s_tdata[97:66];
					neg_q        <= s_tdata[65];
					mag_q        <= s_tdata[65] ? (~s_tdata[65:2] + KEY_W'(1)) : s_tdata[65:2];
					rem_q        <= '0;
					res_value_q  <= ABSENT_VALUE;
					res_found_q  <= 1'b0;
					res_status_q <= 1'b0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_d;
				mag_q <= mag_q << DIG_W;
			end
			ST_BKT: begin
				// A negative key maps to the non-negative remainder.
				bkt_q <= (neg_q && rem_q != '0) ? BC[BIW-1:0] - rem_q : rem_q;
			end
			ST_HWAIT: begin
				head_q <= head_rdata;
				cur_q  <= head_rdata;
			end
			ST_ENT: begin
				if (key_hit) begin
					res_found_q <= 1'b1;
					slot_q      <= ent_raddr;
					ent_next_q  <= ent_rdata[LW-1:0];
					res_value_q <= (op_q == OP_WRITE) ? wv_q : ent_rdata[LW +: VAL_W];
				end else begin
					cur_q <= ent_rdata[LW-1:0];
				end
			end
			ST_UPD: begin
				if (!res_found_q && op_q != OP_FIND) begin
					if (pool_full) begin
						res_status_q <= 1'b1;
					end else begin
						res_value_q <= (op_q == OP_WRITE) ? wv_q : ABSENT_VALUE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_value_q  <= res_value_q;
					m_found_q  <= res_found_q;
					m_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== dv/chm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker: result predictor and comparator for the chained hash map
// Follows every accepted operation and every accepted result, and keeps its
// own copy of the map so that it can check each result as it arrives.
// ----------------------------------------------------------------------------
module chm_checker #(
	parameter int BUCKET_COUNT = 1021,
	parameter int ENTRY_COUNT  = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [chm_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [chm_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              errors,
	output int                              pending
);
	import chm_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             found;
		logic             status;
	} map_result_t;

	// Links are 1-based; zero ends a chain.
	logic [10:0]       head_link  [BUCKET_COUNT];
	logic [KEY_W-1:0]  slot_key   [ENTRY_COUNT];
	logic [VAL_W-1:0]  slot_value [ENTRY_COUNT];
	logic [10:0]       slot_next  [ENTRY_COUNT];
	int                slots_taken;
	map_result_t       awaited_results[$];

	function automatic int home_bucket(logic signed [KEY_W-1:0] key);
		longint rem;
		rem = key % longint'(BUCKET_COUNT);
		if (rem < 0) begin
			rem += BUCKET_COUNT;
		end
		return int'(rem);
	endfunction

	function automatic int find_link(int bkt, logic [KEY_W-1:0] key);
		int link;
		int steps;
		link = head_link[bkt];
		steps = 0;
		while (link != 0 && link <= slots_taken && steps < ENTRY_COUNT) begin
			if (slot_key[link-1] == key) begin
				return link;
			end
			link = slot_next[link-1];
			steps++;
		end
		return 0;
	endfunction

	function automatic map_result_t apply_op(op_t op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] wval);
		map_result_t res;
		int bkt;
		int link;
		res = '{value: ABSENT_VALUE, found: 1'b0, status: 1'b0};
		if (op == OP_CLEAR) begin
			foreach (head_link[i]) head_link[i] = '0;
			slots_taken = 0;
		end else begin
			bkt = home_bucket(key);
			link = find_link(bkt, key);
			if (link != 0) begin
				res.found = 1'b1;
				if (op == OP_WRITE) begin
					slot_value[link-1] = wval;
				end
				res.value = slot_value[link-1];
			end else if (op != OP_FIND) begin
				if (slots_taken >= ENTRY_COUNT) begin
					res.status = 1'b1;
				end else begin
					slot_key[slots_taken] = key;
					slot_value[slots_taken] = (op == OP_WRITE) ? wval : ABSENT_VALUE;
					slot_next[slots_taken] = head_link[bkt];
					slots_taken++;
					head_link[bkt] = 11'(slots_taken);
					res.value = slot_value[slots_taken-1];
				end
			end
		end
		return res;
	endfunction

	task automatic report(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	initial begin
		errors = 0;
		foreach (head_link[i]) head_link[i] = '0;
		slots_taken = 0;
	end

	assign pending = awaited_results.size();

	always @(posedge clk or negedge arst_n) begin
		map_result_t want;
		map_result_t got;
		if (!arst_n) begin
			foreach (head_link[i]) head_link[i] = '0;
			slots_taken = 0;
			awaited_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{value: m_tdata[31:0], found: m_tdata[32], status: m_tdata[33]};
				if (awaited_results.size() == 0) begin
					report($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = awaited_results.pop_front();
					if (got.value !== want.value)
						report($sformatf("value %h, want %h", got.value, want.value));
					if (got.found !== want.found)
						report($sformatf("found %b, want %b", got.found, want.found));
					if (got.status !== want.status)
						report($sformatf("status %b, want %b", got.status, want.status));
				end
			end
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(apply_op(op_t'(s_tdata[1:0]), s_tdata[65:2],
					s_tdata[97:66]));
			end
		end
	end

endmodule

// ===== dv/chained_hash_map_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_core_tb: stimulus and verdict for the chained hash map
// Drives directed and random map operations in bursts, stalls the result
// side on its own pattern, and takes the error count from the checker.
// ----------------------------------------------------------------------------
module chained_hash_map_core_tb;
	import chm_pkg::*;

	localparam int BUCKETS   = 1021;
	localparam int ENTRIES   = 1024;
	localparam int MAX_CYCLE = 800000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     errors;
	int                     pending;
	int                     cycle_count;
	int                     burst_left;
	int                     stall_phase;
	longint                 chain_keys[48];
	longint                 stored_keys[$];

	chained_hash_map_core #(.BUCKET_COUNT(BUCKETS), .ENTRY_COUNT(ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	chm_checker #(.BUCKET_COUNT(BUCKETS), .ENTRY_COUNT(ENTRIES)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The result side cycles through four stall habits: always ready, mostly
	// ready, a fixed duty pattern, and a coin toss.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			case (stall_phase[10:9])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= ($urandom_range(0, 3) != 0);
				2'd2: m_tready <= (stall_phase[2:0] != 3'd5);
				default: m_tready <= $urandom_range(0, 1);
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("chained_hash_map_core verification failed");
			$finish;
		end
	end

	// Sends one operation and waits for its transaction. Between bursts the
	// valid line drops for a random gap; inside a burst it stays high.
	task automatic issue(op_t op, longint key, logic [VAL_W-1:0] wval);
		s_tdata <= {6'b0, wval, key, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 40);
		end else begin
			burst_left--;
		end
	endtask

	function automatic longint fresh_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [VAL_W-1:0] any_value();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		longint k;
		int pick;
		cycle_count = 0;
		burst_left = 3;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		arst_n = 1'b0;
		// Two thirds of the working keys share one bucket, giving a long chain.
		for (int i = 0; i < 32; i++) chain_keys[i] = (longint'(i) - 16) * BUCKETS + 3;
		for (int i = 32; i < 48; i++) chain_keys[i] = fresh_key();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: absent and present keys, extreme keys and values,
		// keys that collide in the first and last buckets, and two clears.
		issue(OP_FIND,  0, 0);
		issue(OP_WRITE, 0, 32'h8000_0000);
		issue(OP_FIND,  0, 0);
		issue(OP_WRITE, 0, 32'h7FFF_FFFF);
		issue(OP_GET,   64'h8000_0000_0000_0000, 0);
		issue(OP_GET,   64'h8000_0000_0000_0000, 0);
		issue(OP_WRITE, 64'h7FFF_FFFF_FFFF_FFFF, 5);
		issue(OP_FIND,  64'h7FFF_FFFF_FFFF_FFFF, 0);
		issue(OP_GET,   -1, 0);
		issue(OP_WRITE, 1020, 32'h1234_5678);
		issue(OP_WRITE, -1, 32'hFFFF_FFFF);
		issue(OP_FIND,  1020, 0);
		issue(OP_FIND,  -1, 0);
		issue(OP_WRITE, BUCKETS, 9);
		issue(OP_FIND,  -BUCKETS, 0);
		issue(OP_FIND,  64'h8000_0000_0000_0000, 0);
		issue(OP_CLEAR, 0, 0);
		issue(OP_FIND,  0, 0);
		issue(OP_GET,   0, 0);
		issue(OP_FIND,  -1, 0);
		issue(OP_CLEAR, fresh_key(), $urandom);

		// Mixed traffic on a small key set, so lookups mostly hit.
		for (int i = 0; i < 100; i++) begin
			k = ($urandom_range(0, 4) == 0) ? fresh_key() : chain_keys[$urandom_range(0, 47)];
			pick = $urandom_range(0, 99);
			if (pick < 2) issue(OP_CLEAR, k, $urandom);
			else if (pick < 35) issue(OP_FIND, k, $urandom);
			else if (pick < 70) issue(OP_WRITE, k, any_value());
			else issue(OP_GET, k, $urandom);
		end

		// Fill the pool to the brim, then run past it so inserts are refused.
		issue(OP_CLEAR, 0, 0);
		for (int i = 0; i < ENTRIES + 20; i++) begin
			k = fresh_key();
			issue($urandom_range(0, 1) ? OP_WRITE : OP_GET, k, any_value());
			stored_keys.push_back(k);
			if ($urandom_range(0, 19) == 0)
				issue(OP_FIND, stored_keys[$urandom_range(0, stored_keys.size() - 1)], 0);
		end
		for (int i = 0; i < 40; i++) begin
			k = stored_keys[$urandom_range(0, ENTRIES - 1)];
			case ($urandom_range(0, 3))
				0: issue(OP_WRITE, fresh_key(), any_value());
				1: issue(OP_WRITE, k, any_value());
				2: issue(OP_GET, fresh_key(), 0);
				default: issue(OP_FIND, k, 0);
			endcase
		end
		issue(OP_CLEAR, 0, 0);
		issue(OP_FIND, stored_keys[0], 0);

		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("chained_hash_map_core verification clean");
		end else begin
			$display("chained_hash_map_core verification failed");
		end
		$finish;
	end

endmodule
